@@ rtl/rtc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_pkg: shared types and constants of the range toggle/count tree
// Node and pair-word layout, link bundles between level cells, FSM states.
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam int MAX_LAMPS  = 1024;
    localparam int TREE_DEPTH = 10;              // log2 of MAX_LAMPS
    localparam int NUM_LEVELS = TREE_DEPTH + 1;  // root .. leaves
    localparam int IDX_W      = TREE_DEPTH;
    localparam int CNT_W      = TREE_DEPTH + 1;
    localparam int LVL_W      = 4;
    localparam int PAIR_W     = TREE_DEPTH - 1;
    localparam int MEM_DEPTH  = MAX_LAMPS / 2;
    localparam int DATA_W     = 32;

    localparam logic [LVL_W-1:0] LEAF_LVL    = LVL_W'(TREE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT     = CNT_W'(1);
    localparam logic [CNT_W-1:0] MAX_LAMPS_C = CNT_W'(MAX_LAMPS);
    localparam logic [CNT_W-1:0] LAMP_RESET  = CNT_W'(MAX_LAMPS);

    // commands
    localparam logic CMD_TOGGLE = 1'b0;
    localparam logic CMD_COUNT  = 1'b1;

    // register index (paddr[2])
    localparam logic REG_LAMP_COUNT = 1'b0;

    // one tree node: on-count of its subtree, pending flip of its children
    typedef struct packed {
        logic             tag;
        logic [CNT_W-1:0] cnt;
    } node_t;

    // two sibling nodes share one memory word, indexed by the parent
    typedef node_t [1:0] pair_t;

    typedef struct packed {
        logic             toggle;
        logic [IDX_W-1:0] start;
        logic [IDX_W-1:0] stop;
    } item_t;

    // top-down link: tag parity along both boundary paths, partial count
    typedef struct packed {
        logic             par_a;
        logic             par_b;
        logic [CNT_W-1:0] sum;
    } dn_t;

    // bottom-up link: rebuilt child sums of both boundary-path nodes
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] sum_a;
        logic [CNT_W-1:0] sum_b;
    } up_t;

    typedef struct packed {
        logic              active;
        logic [PAIR_W-1:0] addr;
    } clr_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    function automatic node_t flip_node(input node_t n, input logic [CNT_W-1:0] size,
                                        input logic leaf);
        node_t r;
        r.cnt = size - n.cnt;
        r.tag = n.tag ^ ~leaf;
        return r;
    endfunction

    function automatic node_t rebuild_node(input node_t n, input logic [CNT_W-1:0] size,
                                           input logic [CNT_W-1:0] sum);
        node_t r;
        r     = n;
        r.cnt = n.tag ? (size - sum) : sum;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/rtc_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_cell: one tree level
// Holds the sibling-pair words of its level; reads both boundary pairs on the
// way down, flips covered nodes and rebuilds path nodes on the way up.
// ----------------------------------------------------------------------------
module rtc_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [rtc_pkg::LVL_W-1:0] lvl,
    input  wire rtc_pkg::item_t            item,
    input  wire rtc_pkg::clr_t             clr,
    input  wire logic                      rd_in,
    input  wire rtc_pkg::dn_t              dn_in,
    input  wire rtc_pkg::up_t              up_in,
    output logic                           rd_out,
    output rtc_pkg::dn_t                   dn_out,
    output rtc_pkg::up_t                   up_out
);

    rtc_pkg::pair_t mem [rtc_pkg::MEM_DEPTH];

    logic [rtc_pkg::LVL_W-1:0]  shamt;
    logic                       leaf;
    logic [rtc_pkg::IDX_W-1:0]  node_a;
    logic [rtc_pkg::IDX_W-1:0]  node_b;
    logic [rtc_pkg::PAIR_W-1:0] pair_a;
    logic [rtc_pkg::PAIR_W-1:0] pair_b;
    logic                       same;
    logic [rtc_pkg::CNT_W-1:0]  size;
    logic [rtc_pkg::CNT_W-1:0]  lo_idx;
    logic [rtc_pkg::CNT_W-1:0]  hi_idx;
    logic                       sel_lo;
    logic                       sel_hi;

    rtc_pkg::pair_t             rd_a_reg;
    rtc_pkg::pair_t             rd_b_reg;
    logic                       data_vld_reg;

    rtc_pkg::node_t             lo_node;
    rtc_pkg::node_t             hi_node;
    logic [rtc_pkg::CNT_W-1:0]  lo_part;
    logic [rtc_pkg::CNT_W-1:0]  hi_part;
    rtc_pkg::dn_t               dn_next;
    rtc_pkg::dn_t               dn_reg;

    logic                       up_go;
    rtc_pkg::pair_t             wa_new;
    rtc_pkg::pair_t             wb_new;
    logic                       up_vld_reg;
    logic [rtc_pkg::CNT_W-1:0]  sum_a_next;
    logic [rtc_pkg::CNT_W-1:0]  sum_b_next;
    logic [rtc_pkg::CNT_W-1:0]  sum_a_reg;
    logic [rtc_pkg::CNT_W-1:0]  sum_b_reg;

    logic                       wb_pend_reg;
    rtc_pkg::pair_t             wb_data_reg;
    logic [rtc_pkg::PAIR_W-1:0] wb_addr_reg;

    logic                       we;
    logic [rtc_pkg::PAIR_W-1:0] waddr;
    rtc_pkg::pair_t             wdata;

    // level geometry; lo/hi are the bottom-up cover bounds at this height
    always_comb
    begin
        shamt  = rtc_pkg::LEAF_LVL - lvl;
        leaf   = (lvl == rtc_pkg::LEAF_LVL);
        node_a = item.start >> shamt;
        node_b = item.stop >> shamt;
        pair_a = node_a[rtc_pkg::IDX_W-1:1];
        pair_b = node_b[rtc_pkg::IDX_W-1:1];
        same   = (pair_a == pair_b);
        size   = rtc_pkg::ONE_CNT << shamt;
        lo_idx = ({1'b0, item.start} + (size - rtc_pkg::ONE_CNT)) >> shamt;
        hi_idx = ({1'b0, item.stop} + rtc_pkg::ONE_CNT) >> shamt;
        sel_lo = (lo_idx < hi_idx) && lo_idx[0];
        sel_hi = (lo_idx < hi_idx) && hi_idx[0];
    end

    // top-down: covered nodes are the right slot of pair A, left slot of B
    always_comb
    begin
        lo_node = rd_a_reg[1];
        hi_node = rd_b_reg[0];
        lo_part = '0;
        hi_part = '0;
        if (sel_lo)
        begin
            lo_part = dn_in.par_a ? (size - lo_node.cnt) : lo_node.cnt;
        end
        if (sel_hi)
        begin
            hi_part = dn_in.par_b ? (size - hi_node.cnt) : hi_node.cnt;
        end
        dn_next.par_a = dn_in.par_a ^ rd_a_reg[node_a[0]].tag;
        dn_next.par_b = dn_in.par_b ^ rd_b_reg[node_b[0]].tag;
        dn_next.sum   = dn_in.sum + lo_part + hi_part;
    end

    // bottom-up: flip covered nodes, then rebuild the path nodes
    always_comb
    begin
        up_go  = leaf ? (data_vld_reg && item.toggle) : up_in.valid;
        wa_new = rd_a_reg;
        wb_new = rd_b_reg;
        if (sel_lo)
        begin
            wa_new[1] = rtc_pkg::flip_node(wa_new[1], size, leaf);
        end
        if (same && sel_hi)
        begin
            wa_new[0] = rtc_pkg::flip_node(wa_new[0], size, leaf);
        end
        if (sel_hi)
        begin
            wb_new[0] = rtc_pkg::flip_node(wb_new[0], size, leaf);
        end
        if (!leaf)
        begin
            wa_new[node_a[0]] = rtc_pkg::rebuild_node(wa_new[node_a[0]], size, up_in.sum_a);
            if (same)
            begin
                wa_new[node_b[0]] = rtc_pkg::rebuild_node(wa_new[node_b[0]], size,
                                                          up_in.sum_b);
            end
            wb_new[node_b[0]] = rtc_pkg::rebuild_node(wb_new[node_b[0]], size, up_in.sum_b);
        end
        sum_a_next = wa_new[0].cnt + wa_new[1].cnt;
        sum_b_next = same ? sum_a_next : (wb_new[0].cnt + wb_new[1].cnt);
    end

    // single write port: clear sweep, pair A now, pair B in the cycle after
    always_comb
    begin
        we    = clr.active || up_go || wb_pend_reg;
        waddr = wb_addr_reg;
        wdata = wb_data_reg;
        if (clr.active)
        begin
            waddr = clr.addr;
            wdata = '0;
        end
        else if (up_go)
        begin
            waddr = pair_a;
            wdata = wa_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_in)
        begin
            rd_a_reg <= mem[pair_a];
            rd_b_reg <= mem[pair_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_vld_reg <= 1'b0;
            up_vld_reg   <= 1'b0;
            wb_pend_reg  <= 1'b0;
        end
        else
        begin
            data_vld_reg <= rd_in;
            up_vld_reg   <= up_go;
            wb_pend_reg  <= up_go && !same;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_vld_reg)
        begin
            dn_reg <= dn_next;
        end
        if (up_go)
        begin
            sum_a_reg   <= sum_a_next;
            sum_b_reg   <= sum_b_next;
            wb_data_reg <= wb_new;
            wb_addr_reg <= pair_b;
        end
    end

    assign rd_out       = data_vld_reg;
    assign dn_out       = dn_reg;
    assign up_out.valid = up_vld_reg;
    assign up_out.sum_a = sum_a_reg;
    assign up_out.sum_b = sum_b_reg;

endmodule
`default_nettype wire

@@ rtl/range_toggle_count_tree.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// range_toggle_count_tree: 1024 lamps with range flip and range count
// Lazy segment tree kept as a chain of per-level cells, root to leaves.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream takes one item per command: s_tuser = command (0 toggle,
//   1 count), s_tdata = {range_end, range_start}. A toggle flips the lamps
//   in the inclusive range and returns nothing; a count returns one item on
//   m_* with m_tdata = lit_count. Only lamps below lamp_count take part; the
//   end of the range is clipped to lamp_count-1, and an empty range flips
//   nothing and counts zero.
//   The block works on one item at a time. A count walks the 11 level cells
//   top-down, one level per cycle, and its result shows on m_tvalid once it
//   is loaded into the output register; the next item can be taken then. A
//   toggle walks down and back up the same chain before the next item is
//   taken. An empty range skips the chain; a count still returns its zero.
//   The result sits in an output register; if the receiver stalls, a second
//   count finishes its walk and waits until that register frees up.
//   After reset the tree memories are swept to zero, one pair word per
//   cycle: s_tready stays low until all 512 words are cleared. lamp_count (APB, address 0)
//   resets to 1024 and may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module range_toggle_count_tree (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [9:0] range_start, [19:10] range_end
    input  wire logic [0:0]  s_tuser,   // [0] command
    // stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [10:0] lit_count
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int NL = rtc_pkg::NUM_LEVELS;

    rtc_pkg::state_t            state_reg;
    rtc_pkg::state_t            state_next;
    logic [rtc_pkg::PAIR_W-1:0] clr_addr_reg;
    logic [rtc_pkg::CNT_W-1:0]  lamp_count_reg;
    rtc_pkg::item_t             item_reg;
    rtc_pkg::item_t             item_next;
    logic                       start_reg;
    logic                       cnt_done_reg;
    logic [rtc_pkg::CNT_W-1:0]  res_reg;
    logic [rtc_pkg::CNT_W-1:0]  res_next;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic [rtc_pkg::CNT_W-1:0]  m_data_reg;

    logic                       accept;
    logic                       cmd;
    logic [rtc_pkg::IDX_W-1:0]  in_start;
    logic [rtc_pkg::IDX_W-1:0]  in_stop;
    logic [rtc_pkg::CNT_W-1:0]  n_use;
    logic [rtc_pkg::CNT_W-1:0]  last_idx;
    logic [rtc_pkg::IDX_W-1:0]  stop_clip;
    logic                       empty;
    logic                       out_free;
    logic                       run_done;
    logic                       ready_int;
    logic                       load_out;
    logic                       cfg_we;
    rtc_pkg::clr_t              clr;

    rtc_pkg::dn_t               dn_link [NL+1];
    rtc_pkg::up_t               up_link [NL+1];
    logic [NL:0]                rd_link;

    // ---------------- input decode and range clipping ----------------
    assign cmd      = s_tuser[0];
    assign in_start = s_tdata[rtc_pkg::IDX_W-1:0];
    assign in_stop  = s_tdata[2*rtc_pkg::IDX_W-1:rtc_pkg::IDX_W];
    assign accept   = s_tvalid && ready_int;

    always_comb
    begin
        n_use     = (lamp_count_reg > rtc_pkg::MAX_LAMPS_C) ? rtc_pkg::MAX_LAMPS_C
                                                            : lamp_count_reg;
        last_idx  = n_use - rtc_pkg::ONE_CNT;
        stop_clip = ({1'b0, in_stop} > last_idx) ? last_idx[rtc_pkg::IDX_W-1:0] : in_stop;
        empty     = (n_use == '0) || (in_start > stop_clip);
        item_next.toggle = (cmd == rtc_pkg::CMD_TOGGLE);
        item_next.start  = in_start;
        item_next.stop   = stop_clip;
    end

    // ---------------- sequencer ----------------
    assign out_free = !m_valid_reg || m_tready;
    assign run_done = item_reg.toggle ? up_link[0].valid : cnt_done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rtc_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = rtc_pkg::ST_IDLE;
                end
            end
            rtc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!empty)
                    begin
                        state_next = rtc_pkg::ST_RUN;
                    end
                    else if (cmd == rtc_pkg::CMD_COUNT)
                    begin
                        state_next = rtc_pkg::ST_HOLD;
                    end
                end
            end
            rtc_pkg::ST_RUN:
            begin
                if (run_done)
                begin
                    state_next = item_reg.toggle ? rtc_pkg::ST_IDLE : rtc_pkg::ST_HOLD;
                end
            end
            rtc_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = rtc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rtc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        ready_int  = (state_reg == rtc_pkg::ST_IDLE);
        load_out   = (state_reg == rtc_pkg::ST_HOLD) && out_free;
        clr.active = (state_reg == rtc_pkg::ST_CLEAR);
        clr.addr   = clr_addr_reg;
    end

    always_comb
    begin
        res_next = res_reg;
        if (accept && empty)
        begin
            res_next = '0;
        end
        else if ((state_reg == rtc_pkg::ST_RUN) && cnt_done_reg)
        begin
            res_next = dn_link[NL].sum;
        end
        m_valid_next = m_valid_reg;
        if (load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rtc_pkg::ST_CLEAR;
            clr_addr_reg   <= '0;
            start_reg      <= 1'b0;
            cnt_done_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            lamp_count_reg <= rtc_pkg::LAMP_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            start_reg    <= accept && !empty;
            cnt_done_reg <= rd_link[NL];
            m_valid_reg  <= m_valid_next;
            if (clr.active)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_we && (paddr[2] == rtc_pkg::REG_LAMP_COUNT))
            begin
                lamp_count_reg <= pwdata[rtc_pkg::CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
        res_reg <= res_next;
        if (load_out)
        begin
            m_data_reg <= res_reg;
        end
    end

    // ---------------- level chain: root (0) .. leaves (10) ----------------
    // rd_link moves the read strobe down one level a cycle; dn_link carries
    // tag parity and the running count in the cycle after it; up_link carries
    // rebuilt child sums from the leaves back to the root for toggles.
    assign rd_link[0]  = start_reg;
    assign dn_link[0]  = '0;
    assign up_link[NL] = '0;

    for (genvar g = 0; g < NL; g++)
    begin : g_level
        localparam int unsigned LvlNum = g;
        rtc_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .lvl    (LvlNum[rtc_pkg::LVL_W-1:0]),
            .item   (item_reg),
            .clr    (clr),
            .rd_in  (rd_link[g]),
            .dn_in  (dn_link[g]),
            .up_in  (up_link[g+1]),
            .rd_out (rd_link[g+1]),
            .dn_out (dn_link[g+1]),
            .up_out (up_link[g])
        );
    end

    // ---------------- ports ----------------
    assign s_tready = ready_int;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16-rtc_pkg::CNT_W){1'b0}}, m_data_reg};

    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == rtc_pkg::REG_LAMP_COUNT)
                    ? {{(rtc_pkg::DATA_W-rtc_pkg::CNT_W){1'b0}}, lamp_count_reg}
                    : '0;

endmodule
`default_nettype wire
